// File: hw/rtl/sidta_pkg.sv
// shared constants for the signed integer to decimal text converter
package sidta_pkg;

  localparam int CHAR_W    = 8;
  localparam int STEP_BITS = 8;
  localparam int DIGIT_W   = 4;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  ASCII_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'd45;
  localparam logic [DIGIT_W-1:0] DIGIT_FIVE  = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_THREE = 4'd3;

endpackage

// File: hw/rtl/sidta_value_if.sv
// request channel carrying one signed value
interface sidta_value_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: hw/rtl/sidta_char_if.sv
// request channel carrying one output character
interface sidta_char_if;
  logic                           valid;
  logic                           ready;
  logic [sidta_pkg::CHAR_W-1:0]   char_code;
  logic                           last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// File: hw/rtl/signed_integer_to_decimal_ascii.sv
// Signed integer to decimal ASCII text converter. Each accepted value comes out as its
// decimal text, one character per request on char_out, most significant first, with a
// leading '-' for negative values, a single '0' for zero, no leading zeros, and
// last_char set on the final character; the most negative value converts exactly.
// The value passes an input register that forms the magnitude, ceil(VALUE_WIDTH/8)
// shift and add-three stages of eight bits each, and a digit count stage.
// The character serialiser sends one character per cycle while char_out is ready, and a
// number's text has 1 to 11 characters at a width of 32 (up to 20 at 64). The serialiser
// takes the next number in the cycle its last character is taken, so numbers follow with
// no gap.
module signed_integer_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  sidta_value_if.sink        value_in,
  sidta_char_if.source       char_out
);

  localparam int STEP       = sidta_pkg::STEP_BITS;
  localparam int NUM_STAGES = (VALUE_WIDTH + STEP - 1) / STEP;
  localparam int PAD_W      = NUM_STAGES * STEP;
  localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int BCD_W      = NUM_DIGITS * sidta_pkg::DIGIT_W;
  localparam int POS_W      = $clog2(NUM_DIGITS);

  logic                rdy;
  logic                rdy_stage0;
  logic                in_vld;
  logic [PAD_W-1:0]    in_bin;
  logic                in_neg;

  logic [NUM_STAGES:0] vld;
  logic [PAD_W-1:0]    bin [NUM_STAGES+1];
  logic [BCD_W-1:0]    bcd [NUM_STAGES+1];
  logic [NUM_STAGES:0] neg;
  logic [NUM_STAGES:0] down_ready;

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag_next;

  logic             len_valid;
  logic             len_ready;
  logic [BCD_W-1:0] len_bcd;
  logic             len_neg;
  logic [POS_W-1:0] len_top;

  logic             ser_ready;

  assign raw      = value_in.value;
  assign mag_next = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

  assign rdy            = !in_vld || rdy_stage0;
  assign value_in.ready = rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (rdy) begin
      in_vld <= value_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && value_in.valid) begin
      in_bin <= PAD_W'(mag_next);
      in_neg <= raw[VALUE_WIDTH-1];
    end
  end

  assign vld[0] = in_vld;
  assign bin[0] = in_bin;
  assign bcd[0] = '0;
  assign neg[0] = in_neg;

  assign rdy_stage0             = down_ready[0];
  assign down_ready[NUM_STAGES] = len_ready;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_dabble
    sidta_dabble_stage #(
      .BIN_W (PAD_W),
      .BCD_W (BCD_W)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k]),
      .in_ready  (down_ready[k]),
      .in_bin    (bin[k]),
      .in_bcd    (bcd[k]),
      .in_neg    (neg[k]),
      .out_valid (vld[k+1]),
      .out_ready (down_ready[k+1]),
      .out_bin   (bin[k+1]),
      .out_bcd   (bcd[k+1]),
      .out_neg   (neg[k+1])
    );
  end

  sidta_length_stage #(
    .BCD_W (BCD_W),
    .POS_W (POS_W)
  ) u_length (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[NUM_STAGES]),
    .in_ready  (len_ready),
    .in_bcd    (bcd[NUM_STAGES]),
    .in_neg    (neg[NUM_STAGES]),
    .out_valid (len_valid),
    .out_ready (ser_ready),
    .out_bcd   (len_bcd),
    .out_neg   (len_neg),
    .out_top   (len_top)
  );

  sidta_serialiser #(
    .BCD_W (BCD_W),
    .POS_W (POS_W)
  ) u_serialiser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (len_valid),
    .in_ready  (ser_ready),
    .in_bcd    (len_bcd),
    .in_neg    (len_neg),
    .in_top    (len_top),
    .out_valid (char_out.valid),
    .out_ready (char_out.ready),
    .out_char  (char_out.char_code),
    .out_last  (char_out.last_char)
  );

`ifndef SYNTH
  a_bin_drained: assert property (@(posedge clk) disable iff (rst)
    vld[NUM_STAGES] |-> (bin[NUM_STAGES] == '0))
    else $error("binary bits left after final conversion stage");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (char_out.valid && (char_out.char_code == sidta_pkg::ASCII_MINUS)) |-> !char_out.last_char)
    else $error("minus sign flagged as last character");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    char_out.valid |-> ((char_out.char_code == sidta_pkg::ASCII_MINUS) ||
                        ((char_out.char_code >= sidta_pkg::ASCII_ZERO) &&
                         (char_out.char_code <= sidta_pkg::ASCII_NINE))))
    else $error("character outside sign and digit codes");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!char_out.valid && !vld[0]))
    else $error("pipeline not empty after reset");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (vld[0] && !rdy_stage0) |=> vld[0])
    else $error("input stage dropped a stalled request");
`endif

endmodule

// File: hw/rtl/sidta_dabble_stage.sv
// one pipeline stage of shift and add-three binary to bcd conversion
module sidta_dabble_stage #(
  parameter int BIN_W = 32,
  parameter int BCD_W = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [BIN_W-1:0] in_bin,
  input  logic [BCD_W-1:0] in_bcd,
  input  logic             in_neg,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [BIN_W-1:0] out_bin,
  output logic [BCD_W-1:0] out_bcd,
  output logic             out_neg
);

  localparam int NUM_DIGITS = BCD_W / sidta_pkg::DIGIT_W;

  logic [BIN_W-1:0] bin_next;
  logic [BCD_W-1:0] bcd_next;

  always_comb begin
    bin_next = in_bin;
    bcd_next = in_bcd;
    for (int s = 0; s < sidta_pkg::STEP_BITS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_next[d*sidta_pkg::DIGIT_W +: sidta_pkg::DIGIT_W] >= sidta_pkg::DIGIT_FIVE) begin
          bcd_next[d*sidta_pkg::DIGIT_W +: sidta_pkg::DIGIT_W] =
            bcd_next[d*sidta_pkg::DIGIT_W +: sidta_pkg::DIGIT_W] + sidta_pkg::DIGIT_THREE;
        end
      end
      bcd_next = {bcd_next[BCD_W-2:0], bin_next[BIN_W-1]};
      bin_next = {bin_next[BIN_W-2:0], 1'b0};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_bin <= bin_next;
      out_bcd <= bcd_next;
      out_neg <= in_neg;
    end
  end

endmodule

// File: hw/rtl/sidta_length_stage.sv
// pipeline stage finding the most significant non-zero digit
module sidta_length_stage #(
  parameter int BCD_W = 40,
  parameter int POS_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [BCD_W-1:0] in_bcd,
  input  logic             in_neg,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [BCD_W-1:0] out_bcd,
  output logic             out_neg,
  output logic [POS_W-1:0] out_top
);

  localparam int NUM_DIGITS = BCD_W / sidta_pkg::DIGIT_W;

  logic [POS_W-1:0] top_next;

  // zero keeps top index 0, giving a single '0'
  always_comb begin
    top_next = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (in_bcd[d*sidta_pkg::DIGIT_W +: sidta_pkg::DIGIT_W] != '0) begin
        top_next = POS_W'(d);
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_bcd <= in_bcd;
      out_neg <= in_neg;
      out_top <= top_next;
    end
  end

endmodule

// File: hw/rtl/sidta_serialiser.sv
// output stage sending the sign and digits one character per cycle while out_ready is high
module sidta_serialiser #(
  parameter int BCD_W = 40,
  parameter int POS_W = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [BCD_W-1:0]             in_bcd,
  input  logic                         in_neg,
  input  logic [POS_W-1:0]             in_top,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sidta_pkg::CHAR_W-1:0] out_char,
  output logic                         out_last
);

  logic [BCD_W-1:0] bcd;
  logic             sign_pending;
  logic [POS_W-1:0] pos;
  logic [sidta_pkg::DIGIT_W-1:0] digit;
  logic             sent;

  assign digit     = bcd[pos*sidta_pkg::DIGIT_W +: sidta_pkg::DIGIT_W];
  assign out_char  = sign_pending ? sidta_pkg::ASCII_MINUS
                                  : sidta_pkg::ASCII_ZERO + sidta_pkg::CHAR_W'(digit);
  assign out_last  = !sign_pending && (pos == '0);
  assign sent      = out_valid && out_ready;
  assign in_ready  = !out_valid || (out_ready && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      sign_pending <= 1'b0;
    end else if (in_ready && in_valid) begin
      out_valid    <= 1'b1;
      sign_pending <= in_neg;
    end else if (sent) begin
      if (sign_pending) begin
        sign_pending <= 1'b0;
      end else if (pos == '0) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      bcd <= in_bcd;
      pos <= in_top;
    end else if (sent && !sign_pending && (pos != '0)) begin
      pos <= pos - 1'b1;
    end
  end

endmodule

// File: dv/signed_integer_to_decimal_ascii_tb.sv
// testbench for the signed integer to decimal ascii converter
module signed_integer_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_WIDTH   = 32;
  localparam int DECIMAL_RADIX = 10;
  localparam int DRAIN_CYCLES  = 32;
  localparam int LONG_HOLD     = 300;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic [sidta_pkg::CHAR_W-1:0] code;
    logic                         last;
  } text_char_t;

  localparam value_t MOST_NEGATIVE = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam value_t MOST_POSITIVE = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  logic clk = 1'b0;
  logic rst = 1'b1;

  sidta_value_if #(.VALUE_WIDTH(VALUE_WIDTH)) value_bus ();
  sidta_char_if char_bus ();

  signed_integer_to_decimal_ascii #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .value_in (value_bus),
    .char_out (char_bus)
  );

  text_char_t  pending_text[$];
  text_char_t  oldest_char;
  int unsigned mismatches   = 0;
  int unsigned send_idle    = 0;
  int unsigned take_idle    = 0;
  int unsigned hold_cycles  = 0;

  always #5 clk = ~clk;

  function automatic void queue_decimal_text(input value_t number);
    logic [VALUE_WIDTH-1:0]       mag;
    logic [sidta_pkg::CHAR_W-1:0] digits[$];
    text_char_t                   ch;
    mag = number;
    if (number[VALUE_WIDTH-1]) begin
      mag = ~mag + 1'b1;
    end
    do begin
      digits.push_front(sidta_pkg::ASCII_ZERO +
                        sidta_pkg::CHAR_W'(mag % DECIMAL_RADIX));
      mag = mag / DECIMAL_RADIX;
    end while (mag != 0);
    if (number[VALUE_WIDTH-1]) begin
      ch.code = sidta_pkg::ASCII_MINUS;
      ch.last = 1'b0;
      pending_text.push_back(ch);
    end
    foreach (digits[i]) begin
      ch.code = digits[i];
      ch.last = (i == digits.size() - 1);
      pending_text.push_back(ch);
    end
  endfunction

  function automatic value_t random_value();
    longint pow;
    int     digits;
    int     i;
    value_t pick;
    pow = 1;
    case ($urandom_range(3))
      0: begin
        pick = $urandom;
      end
      1: begin
        digits = $urandom_range(10, 1);
        for (i = 0; i < digits; i++) pow = pow * DECIMAL_RADIX;
        pick = value_t'(longint'($urandom) % pow);
        if ($urandom_range(1)) pick = -pick;
      end
      2: begin
        digits = $urandom_range(9, 0);
        for (i = 0; i < digits; i++) pow = pow * DECIMAL_RADIX;
        pick = value_t'(pow + $urandom_range(2) - 1);
        if ($urandom_range(1)) pick = -pick;
      end
      default: begin
        case ($urandom_range(5))
          0: pick = MOST_NEGATIVE;
          1: pick = MOST_NEGATIVE + 1;
          2: pick = MOST_POSITIVE;
          3: pick = MOST_POSITIVE - 1;
          4: pick = '0;
          default: pick = '1;
        endcase
      end
    endcase
    return pick;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // request stays up into the next call when there is no gap
  task automatic send_value(input value_t number);
    value_bus.valid <= 1'b1;
    value_bus.value <= number;
    do @(posedge clk); while (!value_bus.ready);
    queue_decimal_text(number);
    while ($urandom_range(99) < send_idle) begin
      value_bus.valid <= 1'b0;
      value_bus.value <= $urandom;
      @(posedge clk);
    end
  endtask

  task automatic wait_all_taken();
    value_bus.valid <= 1'b0;
    wait (pending_text.size() == 0);
    @(posedge clk);
  endtask

  task automatic test_directed();
    value_t corner[$];
    corner = '{0, 1, -1, 9, -9, 10, -10, 99, 100, 9999, 10000, -10000,
               12345, -98765, 999999999, 1000000000, -1000000000,
               32'sh5555_5555, 32'shAAAA_AAAA, MOST_POSITIVE, MOST_NEGATIVE,
               MOST_NEGATIVE + 1};
    send_idle = 31;
    take_idle = 57;
    foreach (corner[i]) send_value(corner[i]);
  endtask

  task automatic test_random_mix();
    int n;
    for (n = 0; n < 360; n++) begin
      if (n == 0) begin
        send_idle = 31;
        take_idle = 57;
      end else if (n == 120) begin
        send_idle = 57;
        take_idle = 31;
      end else if (n == 240) begin
        send_idle = 0;
        take_idle = 0;
      end
      send_value(random_value());
    end
  endtask

  // sink held off long enough that the converter backs up into its input
  task automatic test_input_stall();
    int n;
    send_idle = 0;
    take_idle = 0;
    hold_cycles = LONG_HOLD;
    for (n = 0; n < 30; n++) send_value(random_value());
  endtask

  task automatic test_drain_pause();
    int n;
    send_idle = 31;
    take_idle = 31;
    for (n = 0; n < 4; n++) send_value(random_value());
    wait_all_taken();
    for (n = 0; n < 4; n++) send_value(random_value());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      char_bus.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      char_bus.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      char_bus.ready <= ($urandom_range(99) >= take_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && char_bus.valid && char_bus.ready) begin
      if (pending_text.size() == 0) begin
        report_mismatch("unexpected character", char_bus.char_code, 0);
      end else begin
        oldest_char = pending_text.pop_front();
        if (char_bus.char_code !== oldest_char.code)
          report_mismatch("char_code", char_bus.char_code, oldest_char.code);
        if (char_bus.last_char !== oldest_char.last)
          report_mismatch("last_char", char_bus.last_char, oldest_char.last);
      end
    end
  end

  initial begin
    value_bus.valid = 1'b0;
    value_bus.value = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mix();
    test_input_stall();
    test_drain_pause();
    wait_all_taken();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("signed_integer_to_decimal_ascii_tb passed");
    end else begin
      $display("signed_integer_to_decimal_ascii_tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("signed_integer_to_decimal_ascii_tb failed");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/sidta_pkg.sv
hw/rtl/sidta_value_if.sv
hw/rtl/sidta_char_if.sv
hw/rtl/sidta_dabble_stage.sv
hw/rtl/sidta_length_stage.sv
hw/rtl/sidta_serialiser.sv
hw/rtl/signed_integer_to_decimal_ascii.sv
dv/signed_integer_to_decimal_ascii_tb.sv
